@@ hw/rtl/sha_pkg.sv @@
`timescale 1ns / 1ps
// shared types, control groups and constants for the sha-256 byte hasher
// depends on nothing; imported by every module of the block
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } digest_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_COMPRESS,
    ST_FINAL_ADD,
    ST_OUTPUT
  } fsm_state_t;

  typedef struct packed {
    logic       shift_byte;
    logic [7:0] new_byte;
    logic       step;
  } sched_ctrl_t;

  typedef struct packed {
    logic load;
    logic round;
    logic add;
    logic rotate;
    logic reinit;
  } round_ctrl_t;

  localparam logic [5:0] PAD_LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS    = 6'd63;
  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [2:0] LAST_WORD   = 3'd7;
  localparam logic [7:0] PAD_MARK    = 8'h80;

  localparam logic [31:0] INIT_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

@@ hw/rtl/sha_sched.sv @@
`timescale 1ns / 1ps
// block buffer and message schedule window: bytes shift in, then the
// same sixteen words slide by one schedule word per round; uses sha_pkg
module sha_sched
  import sha_pkg::*;
(
  input  logic        clk,
  input  sched_ctrl_t ctrl,
  output logic [31:0] w
);

  logic [31:0] win [16];
  logic [31:0] s0;
  logic [31:0] s1;
  logic [31:0] w_new;

  assign s0 = {win[1][6:0], win[1][31:7]} ^ {win[1][17:0], win[1][31:18]}
            ^ (win[1] >> 3);
  assign s1 = {win[14][16:0], win[14][31:17]} ^ {win[14][18:0], win[14][31:19]}
            ^ (win[14] >> 10);
  assign w_new = win[0] + s0 + win[9] + s1;
  assign w = win[0];

  always_ff @(posedge clk) begin
    if (ctrl.shift_byte) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[15] <= {win[15][23:0], ctrl.new_byte};
    end else if (ctrl.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
    end
  end

endmodule

@@ hw/rtl/sha_round.sv @@
`timescale 1ns / 1ps
// working variables with the one-per-cycle compression round, and the
// chain value with its final addition and word-by-word readout; uses sha_pkg
module sha_round
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  round_ctrl_t ctrl,
  input  logic [31:0] k,
  input  logic [31:0] w,
  output logic [31:0] head
);

  logic [31:0] chain [8];
  logic [31:0] v [8];
  logic [31:0] big0;
  logic [31:0] big1;
  logic [31:0] choose;
  logic [31:0] major;
  logic [31:0] t1;
  logic [31:0] t2;

  assign big1   = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
                ^ {v[4][24:0], v[4][31:25]};
  assign choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1     = v[7] + big1 + choose + k + w;
  assign big0   = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
                ^ {v[0][21:0], v[0][31:22]};
  assign major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2     = big0 + major;
  assign head   = chain[0];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= chain[i];
      end
    end else if (ctrl.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= INIT_WORDS[i];
      end
    end else if (ctrl.add) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + v[i];
      end
    end else if (ctrl.reinit) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= INIT_WORDS[i];
      end
    end else if (ctrl.rotate) begin
      for (int i = 0; i < 7; i++) begin
        chain[i] <= chain[i+1];
      end
      chain[7] <= chain[0];
    end
  end

endmodule

@@ hw/rtl/sha256_hash.sv @@
`timescale 1ns / 1ps
// sha-256 over a byte stream: one byte per word in, eight digest words out
// a byte that does not fill the block is taken straight in; the 64th byte of a block
// starts 64 rounds on the shared round unit, then the chain addition, and no byte is
// taken meanwhile; last word: padding inserts one byte per cycle (up to 63 zero bytes,
// 8 length bytes) with one or two compressions, then 8 digest words at one per cycle
// while digest_ready is high; reset: synchronous, chain to initial words
module sha256_hash
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_item_t byte_item,
  output logic       digest_valid,
  input  logic       digest_ready,
  output digest_t    digest
);

  fsm_state_t  state;
  fsm_state_t  state_next;
  fsm_state_t  resume;
  fsm_state_t  resume_next;
  logic [5:0]  pos;
  logic [63:0] len;
  logic [5:0]  cnt;
  logic        ins;
  logic [7:0]  ins_byte;
  logic        wrap;
  logic [31:0] w;
  logic [31:0] head;
  sched_ctrl_t sc;
  round_ctrl_t rc;

  assign wrap = ins && (pos == LAST_POS);

  // outputs of the sequencer
  always_comb begin
    ins          = 1'b0;
    ins_byte     = '0;
    byte_ready   = 1'b0;
    digest_valid = 1'b0;
    rc           = '0;
    case (state)
      ST_IDLE: begin
        byte_ready = 1'b1;
        if (byte_valid && byte_item.byte_present) begin
          ins      = 1'b1;
          ins_byte = byte_item.data_byte;
        end
      end
      ST_PAD_MARK: begin
        ins      = 1'b1;
        ins_byte = PAD_MARK;
      end
      ST_PAD_ZERO: begin
        ins = (pos != PAD_LEN_POS);
      end
      ST_PAD_LEN: begin
        ins      = 1'b1;
        ins_byte = len[63:56];
      end
      ST_COMPRESS: begin
        rc.round = 1'b1;
      end
      ST_FINAL_ADD: begin
        rc.add = 1'b1;
      end
      ST_OUTPUT: begin
        digest_valid = 1'b1;
        rc.rotate    = digest_ready;
        rc.reinit    = digest_ready && (cnt[2:0] == LAST_WORD);
      end
      default: begin
        ins = 1'b0;
      end
    endcase
    rc.load       = wrap;
    sc.shift_byte = ins;
    sc.new_byte   = ins_byte;
    sc.step       = (state == ST_COMPRESS);
  end

  // next state
  always_comb begin
    state_next  = state;
    resume_next = resume;
    case (state)
      ST_IDLE: begin
        if (byte_valid) begin
          if (wrap) begin
            state_next  = ST_COMPRESS;
            resume_next = byte_item.end_of_message ? ST_PAD_MARK : ST_IDLE;
          end else if (byte_item.end_of_message) begin
            state_next = ST_PAD_MARK;
          end
        end
      end
      ST_PAD_MARK: begin
        state_next  = wrap ? ST_COMPRESS : ST_PAD_ZERO;
        resume_next = ST_PAD_ZERO;
      end
      ST_PAD_ZERO: begin
        if (pos == PAD_LEN_POS) begin
          state_next = ST_PAD_LEN;
        end else if (wrap) begin
          state_next  = ST_COMPRESS;
          resume_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_LEN: begin
        if (wrap) begin
          state_next  = ST_COMPRESS;
          resume_next = ST_OUTPUT;
        end
      end
      ST_COMPRESS: begin
        if (cnt == LAST_ROUND) begin
          state_next = ST_FINAL_ADD;
        end
      end
      ST_FINAL_ADD: begin
        state_next = resume;
      end
      ST_OUTPUT: begin
        if (digest_ready && (cnt[2:0] == LAST_WORD)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      resume <= ST_IDLE;
      pos    <= '0;
      len    <= '0;
      cnt    <= '0;
    end else begin
      state  <= state_next;
      resume <= resume_next;
      if (ins) begin
        pos <= pos + 6'd1;
      end
      // length counts up while bytes arrive and empties as its bytes are padded in
      if (state == ST_PAD_LEN) begin
        len <= {len[55:0], 8'h00};
      end else if (state == ST_IDLE && byte_valid && byte_item.byte_present) begin
        len <= len + 64'd8;
      end
      if (state_next != state) begin
        cnt <= '0;
      end else if (state == ST_COMPRESS || (state == ST_OUTPUT && digest_ready)) begin
        cnt <= cnt + 6'd1;
      end
    end
  end

  assign digest.digest_word = head;
  assign digest.word_index  = cnt[2:0];
  assign digest.final_word  = (cnt[2:0] == LAST_WORD);

  sha_sched u_sched (
    .clk  (clk),
    .ctrl (sc),
    .w    (w)
  );

  sha_round u_round (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rc),
    .k    (ROUND_K[cnt]),
    .w    (w),
    .head (head)
  );

endmodule

@@ hw/rtl/sha_checker.sv @@
`timescale 1ns / 1ps
// port-level checks on the sha-256 byte hasher, bound to the top level
// depends on sha_pkg and sha256_hash
module sha_checker
  import sha_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       byte_valid,
  input logic       byte_ready,
  input byte_item_t byte_item,
  input logic       digest_valid,
  input logic       digest_ready,
  input digest_t    digest
);

  // a stalled digest word holds
  a_digest_hold: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> digest_valid && $stable(digest))
    else $error("digest word changed while stalled");

  // no byte is taken while digest words are on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    byte_ready |-> !digest_valid)
    else $error("byte ready while digest pending");

  // digest words come in index order without gaps
  a_index_seq: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && !digest.final_word
      |=> digest_valid && digest.word_index == 3'($past(digest.word_index) + 3'd1))
    else $error("digest word index out of order");

  // the run ends after the final word
  a_final_end: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && digest.final_word |=> !digest_valid)
    else $error("digest word after final word");

  // a message end is never followed straight away by another byte
  a_pad_busy: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready && byte_item.end_of_message |=> !byte_ready)
    else $error("byte ready right after message end");

endmodule

bind sha256_hash sha_checker u_sha_checker (.*);
